>>> rtl/crc_pkg.sv
package crc_pkg;

    localparam int MAP_SIZE_DEF  = 16;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int STEP_SIZE_DEF = 41;

    localparam int DIV_N     = 26;   // dividend bits of the shared divider
    localparam int DVS_W     = 18;   // divisor bits
    localparam int CORDIC_N  = 14;
    localparam int CNT_W     = 5;
    localparam int XY_W      = 18;
    localparam int Z_W       = 17;

    localparam logic [15:0] CORDIC_GAIN_SEED = 16'd9949;

    localparam logic [2:0] CFG_PLAYER_X      = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y      = 3'd1;
    localparam logic [2:0] CFG_PLAYER_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_FIELD_OF_VIEW = 3'd3;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd5;

    localparam logic OP_MAP_ROW = 1'b0;
    localparam logic OP_CAST    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG_DIV,
        ST_CORD_INIT,
        ST_CORDIC,
        ST_MARCH_INIT,
        ST_MARCH,
        ST_RESOLVE,
        ST_CEIL_LOAD,
        ST_CEIL_DIV,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic map_wr;
        logic ang_init;
        logic div_step;
        logic cord_init;
        logic cord_step;
        logic march_init;
        logic march_step;
        logic resolve;
        logic ceil_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic cordic_last;
        logic march_stop;
    } t_status;

    function automatic logic [Z_W-1:0] cordic_atan(input logic [CNT_W-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = 17'd8192;
            5'd1:    v = 17'd4836;
            5'd2:    v = 17'd2555;
            5'd3:    v = 17'd1297;
            5'd4:    v = 17'd651;
            5'd5:    v = 17'd326;
            5'd6:    v = 17'd163;
            5'd7:    v = 17'd81;
            5'd8:    v = 17'd41;
            5'd9:    v = 17'd20;
            5'd10:   v = 17'd10;
            5'd11:   v = 17'd5;
            5'd12:   v = 17'd3;
            5'd13:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/crc_in_if.sv
interface crc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [9:0]  column;
    logic [3:0]  row_index;
    logic [15:0] row_bits;

    modport source (output valid, opcode, column, row_index, row_bits, input ready);
    modport sink   (input valid, opcode, column, row_index, row_bits, output ready);
endinterface

>>> rtl/crc_out_if.sv
interface crc_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         column_out;
    logic               hit;
    logic [16:0]        distance;
    logic [11:0]        texture_u;
    logic signed [11:0] ceiling_row;
    logic [11:0]        floor_row;

    modport source (output valid, column_out, hit, distance, texture_u, ceiling_row,
                    floor_row, input ready);
    modport sink   (input valid, column_out, hit, distance, texture_u, ceiling_row,
                    floor_row, output ready);
endinterface

>>> rtl/column_ray_caster.sv
// Fixed-step ray-march caster over a wall bitmap. An opcode 0 transfer loads
// one map row (x cell) and yields no result. An opcode 1 transfer casts one
// screen column and yields one result transfer. A cast runs in order: the
// accept, the column-angle divide, seeding the rotation, 14 CORDIC iterations,
// setting up the march, the march steps (up to ceil(MAX_DEPTH*4096/STEP_SIZE)
// steps, 1599 at the defaults, and a final check that takes no step when the
// depth runs out), the resolve, the load and the ceiling divide, and the
// output, which waits while the previous result is still waiting in the
// output register. No new transfer is taken until the cast is done. The march
// loop is the rate-setting part; the two divides share one radix-2 divider.
// A finished result sits in an output register while the next transfer is
// taken. Configuration is a plain write port: index per register order
// (player x, player y, angle, field of view, screen width, screen height);
// write only while idle.
module column_ray_caster #(
    parameter int MAP_SIZE  = crc_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH = crc_pkg::MAX_DEPTH_DEF,
    parameter int STEP_SIZE = crc_pkg::STEP_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    crc_in_if.sink      i_item,
    crc_out_if.source   o_result
);

    crc_pkg::t_cmd    cmd;
    crc_pkg::t_status status;

    // sequencer: owns handshakes and the output valid flag
    crc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_opcode (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: config, map, divider, CORDIC, march and result registers
    crc_dp #(
        .MAP_SIZE  (MAP_SIZE),
        .MAX_DEPTH (MAX_DEPTH),
        .STEP_SIZE (STEP_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_column      (i_item.column),
        .i_row_index   (i_item.row_index),
        .i_row_bits    (i_item.row_bits),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_column_out  (o_result.column_out),
        .o_hit         (o_result.hit),
        .o_distance    (o_result.distance),
        .o_texture_u   (o_result.texture_u),
        .o_ceiling_row (o_result.ceiling_row),
        .o_floor_row   (o_result.floor_row)
    );

endmodule

>>> rtl/crc_ctrl.sv
module crc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_opcode,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  crc_pkg::t_status i_status,
    output crc_pkg::t_cmd    o_cmd
);

    crc_pkg::t_state r_state, n_state;
    logic            r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crc_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crc_pkg::ST_IDLE:
                if (i_in_valid && i_in_opcode == crc_pkg::OP_CAST) n_state = crc_pkg::ST_ANG_DIV;
            crc_pkg::ST_ANG_DIV:
                if (i_status.div_last) n_state = crc_pkg::ST_CORD_INIT;
            crc_pkg::ST_CORD_INIT:  n_state = crc_pkg::ST_CORDIC;
            crc_pkg::ST_CORDIC:
                if (i_status.cordic_last) n_state = crc_pkg::ST_MARCH_INIT;
            crc_pkg::ST_MARCH_INIT: n_state = crc_pkg::ST_MARCH;
            crc_pkg::ST_MARCH:
                if (i_status.march_stop) n_state = crc_pkg::ST_RESOLVE;
            crc_pkg::ST_RESOLVE:    n_state = crc_pkg::ST_CEIL_LOAD;
            crc_pkg::ST_CEIL_LOAD:  n_state = crc_pkg::ST_CEIL_DIV;
            crc_pkg::ST_CEIL_DIV:
                if (i_status.div_last) n_state = crc_pkg::ST_OUTPUT;
            crc_pkg::ST_OUTPUT:
                if (!r_ov || i_out_ready) n_state = crc_pkg::ST_IDLE;
            default: n_state = crc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            crc_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.map_wr   = i_in_valid && i_in_opcode == crc_pkg::OP_MAP_ROW;
                o_cmd.ang_init = i_in_valid && i_in_opcode == crc_pkg::OP_CAST;
            end
            crc_pkg::ST_ANG_DIV:    o_cmd.div_step   = 1'b1;
            crc_pkg::ST_CORD_INIT:  o_cmd.cord_init  = 1'b1;
            crc_pkg::ST_CORDIC:     o_cmd.cord_step  = 1'b1;
            crc_pkg::ST_MARCH_INIT: o_cmd.march_init = 1'b1;
            crc_pkg::ST_MARCH:      o_cmd.march_step = 1'b1;
            crc_pkg::ST_RESOLVE:    o_cmd.resolve    = 1'b1;
            crc_pkg::ST_CEIL_LOAD:  o_cmd.ceil_load  = 1'b1;
            crc_pkg::ST_CEIL_DIV:   o_cmd.div_step   = 1'b1;
            crc_pkg::ST_OUTPUT:     o_cmd.out_load   = !r_ov || i_out_ready;
            default: ;
        endcase
    end

    assign n_ov        = (r_ov && !i_out_ready) || o_cmd.out_load;
    assign o_out_valid = r_ov;

endmodule

>>> rtl/crc_dp.sv
module crc_dp #(
    parameter int MAP_SIZE  = crc_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH = crc_pkg::MAX_DEPTH_DEF,
    parameter int STEP_SIZE = crc_pkg::STEP_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [9:0]         i_column,
    input  logic [3:0]         i_row_index,
    input  logic [15:0]        i_row_bits,
    input  crc_pkg::t_cmd      i_cmd,
    output crc_pkg::t_status   o_status,
    output logic [9:0]         o_column_out,
    output logic               o_hit,
    output logic [16:0]        o_distance,
    output logic [11:0]        o_texture_u,
    output logic signed [11:0] o_ceiling_row,
    output logic [11:0]        o_floor_row
);

    localparam int ROWS  = (MAP_SIZE < 16) ? MAP_SIZE : 16;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [16:0] DEPTH_Q = 17'(MAX_DEPTH * 4096);
    localparam logic [16:0] STEP_D  = 17'(STEP_SIZE);
    localparam logic signed [13:0] STEP_S = 14'(STEP_SIZE);
    localparam int ACC_W = 35;
    localparam int P_W   = 23;

    // configuration
    logic [15:0] r_px0, r_py0, r_ang, r_fov;
    logic [9:0]  r_sw, r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px0 <= 16'd32768;
            r_py0 <= 16'd32768;
            r_ang <= 16'd0;
            r_fov <= 16'd8192;
            r_sw  <= 10'd650;
            r_sh  <= 10'd480;
        end else if (i_cfg_we) begin
            priority case (i_cfg_idx)
                crc_pkg::CFG_PLAYER_X:      r_px0 <= i_cfg_data;
                crc_pkg::CFG_PLAYER_Y:      r_py0 <= i_cfg_data;
                crc_pkg::CFG_PLAYER_ANGLE:  r_ang <= i_cfg_data;
                crc_pkg::CFG_FIELD_OF_VIEW: r_fov <= i_cfg_data;
                crc_pkg::CFG_SCREEN_WIDTH:  r_sw  <= i_cfg_data[9:0];
                crc_pkg::CFG_SCREEN_HEIGHT: r_sh  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // wall map
    logic [15:0] r_map [ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROWS; k++) r_map[k] <= '0;
        end else if (i_cmd.map_wr && 32'(i_row_index) < ROWS) begin
            r_map[i_row_index[ROW_W-1:0]] <= i_row_bits;
        end
    end

    // shared restoring divider and step counter
    logic [crc_pkg::DIV_N-1:0] r_quo;
    logic [crc_pkg::DVS_W-1:0] r_rem, r_dvs;
    logic [crc_pkg::CNT_W-1:0] r_cnt;
    logic [crc_pkg::DVS_W:0]   rem_sh, rem_sub;
    logic                      q_bit;

    assign rem_sh  = {r_rem, r_quo[crc_pkg::DIV_N-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_bit   = rem_sh >= {1'b0, r_dvs};

    // cordic
    logic signed [crc_pkg::XY_W-1:0] r_x, r_y, xs, ys;
    logic signed [crc_pkg::Z_W-1:0]  r_z;
    logic                            r_flip;
    logic [15:0]                     ra, ra_f;

    assign xs   = r_x >>> r_cnt;
    assign ys   = r_y >>> r_cnt;
    assign ra   = r_ang - {1'b0, r_fov[15:1]} + r_quo[15:0];
    assign ra_f = (ra >= 16'd16384 && ra < 16'd49152) ? ra + 16'd32768 : ra;

    // march
    logic signed [crc_pkg::XY_W-1:0] ex, ey;
    logic signed [31:0]              r_sx, r_sy;
    logic signed [ACC_W-1:0]         r_ax, r_ay, ax_n, ay_n, sh_x, sh_y;
    logic [16:0]                     r_d, d_n;
    logic signed [P_W-1:0]           r_ppx, r_ppy, px_n, py_n;
    logic signed [P_W-13:0]          cx_n, cy_n;
    logic                            r_struck, in_map, wall;
    logic [15:0]                     row_w;

    assign ex   = r_flip ? -r_x : r_x;
    assign ey   = r_flip ? -r_y : r_y;
    assign d_n  = r_d + STEP_D;
    assign ax_n = r_ax + ACC_W'(r_sx);
    assign ay_n = r_ay + ACC_W'(r_sy);
    assign sh_x = ax_n >>> 14;
    assign sh_y = ay_n >>> 14;
    assign px_n = P_W'(signed'({1'b0, r_px0})) + sh_x[P_W-1:0];
    assign py_n = P_W'(signed'({1'b0, r_py0})) + sh_y[P_W-1:0];
    assign cx_n = px_n[P_W-1:12];
    assign cy_n = py_n[P_W-1:12];
    assign in_map = !cx_n[P_W-13] && !cy_n[P_W-13]
                 && 32'(cx_n) < MAP_SIZE && 32'(cy_n) < MAP_SIZE;
    assign row_w  = (32'(cx_n) < ROWS) ? r_map[cx_n[ROW_W-1:0]] : 16'd0;
    assign wall   = (32'(cy_n) < 16) && row_w[cy_n[3:0]];

    // resolve: face choice and ceiling operands
    logic        r_hit, r_cneg;
    logic [11:0] r_u;
    logic [11:0] fx, fy, adx, ady;
    logic signed [12:0] dx, dy;
    logic        take_y, hit_c;
    logic signed [18:0] diff;
    logic [16:0] dmag;
    logic [26:0] prod;

    assign fx  = r_ppx[11:0];
    assign fy  = r_ppy[11:0];
    assign dx  = signed'({1'b0, fx}) - 13'sd2048;
    assign dy  = signed'({1'b0, fy}) - 13'sd2048;
    assign adx = dx[12] ? 12'(-dx) : dx[11:0];
    assign ady = dy[12] ? 12'(-dy) : dy[11:0];
    assign hit_c = r_struck && r_d < DEPTH_Q;

    always_comb begin
        priority if (ady < adx) take_y = 1'b1;
        else if (ady > adx)     take_y = 1'b0;
        else if (dx == 13'sd0)  take_y = 1'b1;
        else                    take_y = !((dx > 0) == (dy > 0));
    end

    assign diff = signed'({2'b0, r_d}) - 19'sd8192;
    assign dmag = diff[18] ? 17'(-diff) : diff[16:0];
    assign prod = 27'(r_sh) * 27'(dmag);

    // output
    logic [11:0] ceil_c;
    logic        sat;

    assign sat    = r_cneg && r_quo > crc_pkg::DIV_N'(2048);
    assign ceil_c = sat ? 12'h800 : (r_cneg ? 12'(-r_quo[11:0]) : r_quo[11:0]);

    logic [9:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ang_init) begin
            r_col <= i_column;
            r_quo <= crc_pkg::DIV_N'(i_column) * crc_pkg::DIV_N'(r_fov);
            r_rem <= '0;
            r_dvs <= (r_sw == 10'd0) ? crc_pkg::DVS_W'(1) : crc_pkg::DVS_W'(r_sw);
        end else if (i_cmd.ceil_load) begin
            r_quo <= prod[crc_pkg::DIV_N-1:0];
            r_rem <= '0;
            r_dvs <= {r_d, 1'b0};
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[crc_pkg::DIV_N-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[crc_pkg::DVS_W-1:0] : rem_sh[crc_pkg::DVS_W-1:0];
        end
        if (i_cmd.cord_init) begin
            r_x    <= crc_pkg::XY_W'(crc_pkg::CORDIC_GAIN_SEED);
            r_y    <= '0;
            r_z    <= crc_pkg::Z_W'(signed'(ra_f));
            r_flip <= ra != ra_f;
        end else if (i_cmd.cord_step) begin
            if (!r_z[crc_pkg::Z_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - crc_pkg::cordic_atan(r_cnt);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + crc_pkg::cordic_atan(r_cnt);
            end
        end
        if (i_cmd.march_init) begin
            r_sx     <= 32'(ex) * 32'(STEP_S);
            r_sy     <= 32'(ey) * 32'(STEP_S);
            r_ax     <= '0;
            r_ay     <= '0;
            r_d      <= '0;
            r_struck <= 1'b0;
        end else if (i_cmd.march_step && r_d < DEPTH_Q) begin
            r_ax     <= ax_n;
            r_ay     <= ay_n;
            r_d      <= d_n;
            r_ppx    <= px_n;
            r_ppy    <= py_n;
            r_struck <= in_map && wall;
        end else if (i_cmd.resolve) begin
            r_hit <= hit_c;
            r_u   <= hit_c ? (take_y ? fy : fx) : 12'd0;
            if (!hit_c) r_d <= DEPTH_Q;
        end
        if (i_cmd.ceil_load) r_cneg <= diff[18];
        if (i_cmd.out_load) begin
            o_column_out  <= r_col;
            o_hit         <= r_hit;
            o_distance    <= r_d;
            o_texture_u   <= r_u;
            o_ceiling_row <= signed'(ceil_c);
            o_floor_row   <= {2'b0, r_sh} - ceil_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ang_init || i_cmd.ceil_load || i_cmd.cord_init) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step || i_cmd.cord_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_status.div_last    = r_cnt == crc_pkg::CNT_W'(crc_pkg::DIV_N - 1);
    assign o_status.cordic_last = r_cnt == crc_pkg::CNT_W'(crc_pkg::CORDIC_N - 1);
    assign o_status.march_stop  = (r_d >= DEPTH_Q) || !in_map || wall;

endmodule
